[rtl/core/uwm_pkg.sv]
// ----------------------------------------------------------------------------
// uwm_pkg
// shared types and constants of the unaligned word memory access unit
// ----------------------------------------------------------------------------
package uwm_pkg;

  localparam int ADDR_W    = 14;           // byte address width
  localparam int DATA_W    = 32;           // word width
  localparam int LANE_W    = 2;            // byte lane select
  localparam int WIDX_W    = ADDR_W - LANE_W; // word index before wrap
  localparam int MEM_WORDS = 4096;         // default memory depth

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_STORE = 1'b1;

  // low word lanes set, shifted up by the byte offset for a store
  localparam logic [2*DATA_W-1:0] WORD_MASK = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_WR0,
    ST_WR1
  } uwm_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the new item
    logic clr_wr;    // clearing pass write
    logic do_mul;    // quotient estimate
    logic do_mod;    // remainder
    logic rd0;       // read first word
    logic rd1;       // read second word
    logic fin_rd;    // second word arrives, load result
    logic wr0;       // write first word
    logic wr1;       // write second word
  } uwm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_store;
    logic aligned;
  } uwm_sts_t;

endpackage

[rtl/core/unaligned_word_memory_access.sv]
// ----------------------------------------------------------------------------
// unaligned_word_memory_access
// byte-addressed little-endian 32-bit load/store over a word memory
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every memory word with busy
// high, then takes an item at each edge where start is high and busy is low.
// Each item first wraps the word index modulo the depth (a reciprocal multiply
// and a remainder step), then uses the single-port word memory one word per
// cycle: a load stays busy through the wrap and its read states, and its
// out_strobe comes in the same cycle in which busy drops; an aligned store
// stays busy through the wrap and one write (no read), an unaligned store
// through the wrap, both word reads and both write-backs. A load result is
// shown for one cycle only and cannot be held off; a store gives no result.
// ----------------------------------------------------------------------------
module unaligned_word_memory_access #(
  parameter int MEM_WORDS = uwm_pkg::MEM_WORDS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // item in
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_mode,
  input  logic [uwm_pkg::ADDR_W-1:0]  in_byte_address,
  input  logic [uwm_pkg::DATA_W-1:0]  in_write_data,
  // load result
  output logic                        out_strobe,
  output logic [uwm_pkg::DATA_W-1:0]  out_read_data
);

  uwm_pkg::uwm_cmd_t cmd;
  uwm_pkg::uwm_sts_t sts;

  // sequencer: clear pass, index wrap, read and write steps
  uwm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // memory, wrap arithmetic and byte lane steering
  uwm_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_byte_address (in_byte_address),
    .in_write_data   (in_write_data),
    .out_strobe      (out_strobe),
    .out_read_data   (out_read_data)
  );

  // every accepted load gives a result strobe
  a_load_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == uwm_pkg::MODE_LOAD) |-> ##6 out_strobe)
    else $error("load result missing");

  // a result only ever follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(busy) && !busy))
    else $error("result strobe without work");

  // a store produces no result during the remainder step of its index wrap
  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == uwm_pkg::MODE_STORE) |=> ##1 !out_strobe)
    else $error("store produced a result");

  // clearing pass holds off items right after reset
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("item window open during clear pass");

endmodule

[rtl/core/uwm_ctrl.sv]
// ----------------------------------------------------------------------------
// uwm_ctrl
// sequencer for index reduction, reads and writes of the word memory
// ----------------------------------------------------------------------------
module uwm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  uwm_pkg::uwm_sts_t sts,
  output uwm_pkg::uwm_cmd_t cmd,
  output logic              busy
);

  uwm_pkg::uwm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uwm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      uwm_pkg::ST_CLEAR: if (sts.clr_last) state_nxt = uwm_pkg::ST_IDLE;
      uwm_pkg::ST_IDLE:  if (start) state_nxt = uwm_pkg::ST_MUL;
      uwm_pkg::ST_MUL:   state_nxt = uwm_pkg::ST_MOD;
      uwm_pkg::ST_MOD: begin
        // aligned store overwrites a whole word, no read needed
        if (sts.is_store && sts.aligned) state_nxt = uwm_pkg::ST_WR0;
        else state_nxt = uwm_pkg::ST_RD0;
      end
      uwm_pkg::ST_RD0:   state_nxt = uwm_pkg::ST_RD1;
      uwm_pkg::ST_RD1:   state_nxt = uwm_pkg::ST_RD2;
      uwm_pkg::ST_RD2: begin
        if (sts.is_store) state_nxt = uwm_pkg::ST_WR0;
        else state_nxt = uwm_pkg::ST_IDLE;
      end
      uwm_pkg::ST_WR0: begin
        if (sts.aligned) state_nxt = uwm_pkg::ST_IDLE;
        else state_nxt = uwm_pkg::ST_WR1;
      end
      uwm_pkg::ST_WR1:   state_nxt = uwm_pkg::ST_IDLE;
      default:           state_nxt = uwm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      uwm_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
      uwm_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      uwm_pkg::ST_MUL:   cmd.do_mul = 1'b1;
      uwm_pkg::ST_MOD:   cmd.do_mod = 1'b1;
      uwm_pkg::ST_RD0:   cmd.rd0    = 1'b1;
      uwm_pkg::ST_RD1:   cmd.rd1    = 1'b1;
      uwm_pkg::ST_RD2:   cmd.fin_rd = 1'b1;
      uwm_pkg::ST_WR0:   cmd.wr0    = 1'b1;
      uwm_pkg::ST_WR1:   cmd.wr1    = 1'b1;
      default:           cmd        = '0;
    endcase
  end

endmodule

[rtl/core/uwm_dp.sv]
// ----------------------------------------------------------------------------
// uwm_dp
// word memory, index wrap, byte gather for loads and merge for stores
// ----------------------------------------------------------------------------
module uwm_dp #(
  parameter int MEM_WORDS = uwm_pkg::MEM_WORDS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  uwm_pkg::uwm_cmd_t           cmd,
  output uwm_pkg::uwm_sts_t           sts,
  input  logic                        in_mode,
  input  logic [uwm_pkg::ADDR_W-1:0]  in_byte_address,
  input  logic [uwm_pkg::DATA_W-1:0]  in_write_data,
  output logic                        out_strobe,
  output logic [uwm_pkg::DATA_W-1:0]  out_read_data
);

  localparam int IW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int XW    = uwm_pkg::WIDX_W;
  localparam int DW    = uwm_pkg::DATA_W;
  // floor reciprocal, quotient estimate is low by at most one
  localparam int RECIP = (1 << XW) / MEM_WORDS;

  logic [DW-1:0] mem [MEM_WORDS];

  logic                        mode_r;
  logic [uwm_pkg::LANE_W-1:0]  lane_r;
  logic [DW-1:0]               wdata_r;
  logic [XW-1:0]               x_r;
  logic [XW-1:0]               q_r;
  logic [XW-1:0]               r_r;
  logic [DW-1:0]               w0_r;
  logic [DW-1:0]               w1_r;
  logic [DW-1:0]               rdata_r;
  logic [DW-1:0]               out_data_r;
  logic                        out_valid_r;
  logic [IW-1:0]               clr_cnt_r;

  logic [2*XW-1:0] q_prod;
  logic [31:0]     qm_prod;
  logic [31:0]     r_ext;
  logic [31:0]     idx0_ext;
  logic [IW-1:0]   idx0;
  logic [IW-1:0]   idx1;
  logic [IW-1:0]   mem_addr;
  logic            mem_we;
  logic [DW-1:0]   mem_wdata;
  logic [4:0]      shamt;
  logic [2*DW-1:0] gather;
  logic [2*DW-1:0] st_data;
  logic [2*DW-1:0] st_mask;
  logic [2*DW-1:0] merged;

  // index wrap modulo depth
  assign q_prod   = {{XW{1'b0}}, x_r} * {{XW{1'b0}}, XW'(RECIP)};
  assign qm_prod  = 32'(q_r) * 32'(MEM_WORDS);
  assign r_ext    = 32'(r_r);
  assign idx0_ext = (r_ext >= 32'(MEM_WORDS)) ? (r_ext - 32'(MEM_WORDS)) : r_ext;
  assign idx0     = idx0_ext[IW-1:0];
  assign idx1     = (idx0 == IW'(MEM_WORDS - 1)) ? '0 : idx0 + IW'(1);

  // byte lane steering
  assign shamt   = {lane_r, 3'b000};
  assign gather  = {rdata_r, w0_r} >> shamt;
  assign st_data = {{DW{1'b0}}, wdata_r} << shamt;
  assign st_mask = uwm_pkg::WORD_MASK << shamt;
  assign merged  = ({w1_r, w0_r} & ~st_mask) | st_data;

  always_comb begin
    mem_we    = cmd.clr_wr | cmd.wr0 | cmd.wr1;
    mem_addr  = idx0;
    mem_wdata = merged[DW-1:0];
    if (cmd.clr_wr) begin
      mem_addr  = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.rd1 || cmd.wr1) begin
      mem_addr  = idx1;
      mem_wdata = merged[2*DW-1:DW];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      lane_r  <= in_byte_address[uwm_pkg::LANE_W-1:0];
      x_r     <= in_byte_address[uwm_pkg::ADDR_W-1:uwm_pkg::LANE_W];
      wdata_r <= in_write_data;
    end
    if (cmd.do_mul) q_r <= q_prod[2*XW-1:XW];
    if (cmd.do_mod) r_r <= x_r - qm_prod[XW-1:0];
    if (cmd.rd1) w0_r <= rdata_r;
    if (cmd.fin_rd) begin
      w1_r       <= rdata_r;
      out_data_r <= gather[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      out_valid_r <= cmd.fin_rd && (mode_r == uwm_pkg::MODE_LOAD);
      if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + IW'(1);
    end
  end

  assign sts.clr_last = (clr_cnt_r == IW'(MEM_WORDS - 1));
  assign sts.is_store = (mode_r == uwm_pkg::MODE_STORE);
  assign sts.aligned  = (lane_r == '0);

  assign out_strobe    = out_valid_r;
  assign out_read_data = out_data_r;

endmodule
